>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL of the deframer.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold as well (cons may be a sequence).
`define RFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// cond must never be true.
`define RFD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/rfd_pkg.sv
`timescale 1ns / 1ps

package rfd_pkg;

    // Header layout: 16 bytes, little endian.
    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned POS_W     = $clog2(HDR_BYTES);
    localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(HDR_BYTES - 1);

    // Record kinds.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic        kind;
        logic [31:0] payload_length;
        logic [31:0] sequence_number;
        logic [15:0] err_code;
        logic [15:0] compress_kind;
        logic [15:0] stream_id;
        logic [15:0] method_id;
        logic [7:0]  payload_byte;
        logic        message_end;
    } t_result;

endpackage

>>> hdl/rpc_frame_deframer_core.sv
// A taken byte goes from the input register through the parser into the queue at the ports.
// Throughput: one byte per cycle unless stalled; header bytes before the last produce no result.
// The input stalls only when a byte waits in the input register and the two-entry queue is full.
// Reset (synchronous, active low) returns the parser to header reception and empties all stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Length-prefixed message deframer.
//
// The design has three parts. An input register captures each accepted byte.
// The parser then handles that byte: in the header phase it
// writes the byte into its lane of the sixteen-byte header and, on the last
// header byte, forms the header record from the completed header; in the
// payload phase it passes the byte on and compares the running count with the
// length to mark the message end. A zero-length header is itself the end of
// the message and the parser stays in the header phase.
//
// Results enter a two-entry queue whose head drives the output ports. The
// input register holds its byte only while the queue is full, so the input
// stall is a decode of registered state and has no combinational path from the
// output stall. With a free-flowing output, one transaction is taken every cycle.
module rpc_frame_deframer_core
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_sequence_number,
    output logic [15:0] o_err_code,
    output logic [15:0] o_compress_kind,
    output logic [15:0] o_stream_id,
    output logic [15:0] o_method_id,
    output logic [7:0]  o_payload_byte,
    output logic        o_message_end
);

    logic    r_in_valid;
    logic    n_in_valid;
    t_byte   r_in_byte;
    logic    q_full;
    logic    fire;
    logic    accept;
    logic    push;
    t_result parse_result;
    t_result head;

    // The held byte is processed whenever the queue can take a result.
    assign fire    = r_in_valid && !q_full;
    assign o_stall = r_in_valid && q_full;
    assign accept  = i_valid && !o_stall;
    assign n_in_valid = accept || (r_in_valid && !fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    rfd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (r_in_byte),
        .o_push      (push),
        .o_result    (parse_result)
    );

    rfd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parse_result),
        .i_stall  (i_stall),
        .o_full   (q_full),
        .o_valid  (o_valid),
        .o_result (head)
    );

    assign o_kind            = head.kind;
    assign o_payload_length  = head.payload_length;
    assign o_sequence_number = head.sequence_number;
    assign o_err_code        = head.err_code;
    assign o_compress_kind   = head.compress_kind;
    assign o_stream_id       = head.stream_id;
    assign o_method_id       = head.method_id;
    assign o_payload_byte    = head.payload_byte;
    assign o_message_end     = head.message_end;

    // A result must never be pushed into a full queue.
    `RFD_ASSERT_NEVER(a_no_overflow, push && q_full, "result pushed into full queue")
    // A byte that could not be processed is kept, unchanged, in the input register.
    `RFD_ASSERT_IMPLY(a_hold_input, r_in_valid && !fire, ##1 (r_in_valid && $stable(r_in_byte)), "held byte lost")

endmodule

>>> hdl/rfd_parse.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Frame parser: header assembly, payload counting and result formation.
module rfd_parse
    import rfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_byte   i_data_byte,
    output logic    o_push,
    output t_result o_result
);

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [31:0] r_count;
    logic [31:0] n_count;
    t_byte       r_hdr [HDR_BYTES];
    t_byte       n_hdr [HDR_BYTES];

    logic [POS_W-1:0] pos;
    logic [31:0]      hdr_len;
    logic [31:0]      new_len;
    logic [32:0]      count_inc;
    logic             payload_last;

    assign pos       = r_count[POS_W-1:0];
    assign hdr_len   = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign new_len   = {n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0]};
    assign count_inc = {1'b0, r_count} + 33'd1;
    assign payload_last = (count_inc >= {1'b0, hdr_len});

    always_comb begin
        n_hdr   = r_hdr;
        n_phase = r_phase;
        n_count = r_count;
        o_push  = 1'b0;
        o_result = '0;

        if (r_phase == PH_HEADER) begin
            n_hdr[pos] = i_data_byte;
            o_result.kind            = KIND_HEADER;
            o_result.payload_length  = new_len;
            o_result.sequence_number = {n_hdr[7], n_hdr[6], n_hdr[5], n_hdr[4]};
            o_result.err_code        = {n_hdr[9], n_hdr[8]};
            o_result.compress_kind   = {n_hdr[11], n_hdr[10]};
            o_result.stream_id       = {n_hdr[13], n_hdr[12]};
            o_result.method_id       = {n_hdr[15], n_hdr[14]};
            o_result.message_end     = (new_len == 32'd0);
            if (pos == HDR_LAST_POS) begin
                o_push  = i_fire;
                n_count = '0;
                if (new_len != 32'd0) begin
                    n_phase = PH_PAYLOAD;
                end
            end else begin
                n_count = 32'({1'b0, pos} + (POS_W+1)'(1));
            end
        end else begin
            o_push = i_fire;
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = i_data_byte;
            o_result.message_end  = payload_last;
            if (payload_last) begin
                n_count = '0;
                n_phase = PH_HEADER;
            end else begin
                n_count = count_inc[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Header bytes are always rewritten before they are used, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hdr <= n_hdr;
        end
    end

    `RFD_ASSERT_IMPLY(a_payload_count, r_phase == PH_PAYLOAD, (r_count < hdr_len), "count past length")
    `RFD_ASSERT_IMPLY(a_header_count, r_phase == PH_HEADER, (r_count < 32'(HDR_BYTES)), "bad header count")

endmodule

>>> hdl/rfd_outq.sv
`timescale 1ns / 1ps

// Two-entry result queue; the head entry drives the output ports.
module rfd_outq
    import rfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_result
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_q [2];
    t_result    n_q [2];
    logic       pop;
    logic [1:0] slot;

    assign o_valid  = (r_cnt != 2'd0);
    assign o_full   = (r_cnt == 2'd2);
    assign o_result = r_q[0];
    assign pop      = o_valid && !i_stall;
    assign slot     = r_cnt - {1'b0, pop};
    assign n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, pop};

    always_comb begin
        n_q = r_q;
        if (pop) begin
            n_q[0] = r_q[1];
        end
        if (i_push) begin
            n_q[slot[0]] = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

>>> test/rfd_stream_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deframer, keeps its own copy of the parser
// state and compares every record leaving the block with the oldest one
// predicted.
module rfd_stream_checker
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_byte       i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_kind,
    input  logic [31:0] i_payload_length,
    input  logic [31:0] i_sequence_number,
    input  logic [15:0] i_err_code,
    input  logic [15:0] i_compress_kind,
    input  logic [15:0] i_stream_id,
    input  logic [15:0] i_method_id,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_message_end,
    output int          o_mismatches,
    output int          o_pending
);

    t_result            pending_records[$];
    t_result            seen_record;
    logic               in_payload;
    logic [POS_W-1:0]   hdr_pos;
    logic [127:0]       hdr_image;
    logic [31:0]        payload_taken;
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    assign seen_record = '{kind:            i_kind,
                           payload_length:  i_payload_length,
                           sequence_number: i_sequence_number,
                           err_code:        i_err_code,
                           compress_kind:   i_compress_kind,
                           stream_id:       i_stream_id,
                           method_id:       i_method_id,
                           payload_byte:    i_payload_byte,
                           message_end:     i_message_end};

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    // Advances the parser copy by one byte and queues the record it yields.
    task automatic take_byte(input t_byte b);
        t_result rec;
        rec = '0;
        if (!in_payload) begin
            hdr_image[hdr_pos*8 +: 8] = b;
            if (hdr_pos != HDR_LAST_POS) begin
                hdr_pos = hdr_pos + 1'b1;
            end else begin
                hdr_pos             = '0;
                rec.kind            = KIND_HEADER;
                rec.payload_length  = hdr_image[31:0];
                rec.sequence_number = hdr_image[63:32];
                rec.err_code        = hdr_image[79:64];
                rec.compress_kind   = hdr_image[95:80];
                rec.stream_id       = hdr_image[111:96];
                rec.method_id       = hdr_image[127:112];
                // An empty message ends with its header.
                rec.message_end     = (hdr_image[31:0] == 32'd0);
                in_payload          = !rec.message_end;
                payload_taken       = '0;
                pending_records     = {pending_records, rec};
            end
        end else begin
            rec.kind         = KIND_PAYLOAD;
            rec.payload_byte = b;
            if ({1'b0, payload_taken} + 33'd1 >= {1'b0, hdr_image[31:0]}) begin
                rec.message_end = 1'b1;
                in_payload      = 1'b0;
                payload_taken   = '0;
            end else begin
                payload_taken   = payload_taken + 32'd1;
            end
            pending_records = {pending_records, rec};
        end
    endtask

    task automatic check_record(input t_result got);
        t_result want;
        if (pending_records.size() == 0) begin
            report_mismatch($sformatf("record with kind %0d arrived unexpectedly", got.kind));
            return;
        end
        want = pending_records[0];
        pending_records.delete(0);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0h, expected %0h", got.kind, want.kind));
        if (got.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0h, expected %0h",
                                      got.payload_length, want.payload_length));
        if (got.sequence_number !== want.sequence_number)
            report_mismatch($sformatf("sequence_number %0h, expected %0h",
                                      got.sequence_number, want.sequence_number));
        if (got.err_code !== want.err_code)
            report_mismatch($sformatf("err_code %0h, expected %0h",
                                      got.err_code, want.err_code));
        if (got.compress_kind !== want.compress_kind)
            report_mismatch($sformatf("compress_kind %0h, expected %0h",
                                      got.compress_kind, want.compress_kind));
        if (got.stream_id !== want.stream_id)
            report_mismatch($sformatf("stream_id %0h, expected %0h",
                                      got.stream_id, want.stream_id));
        if (got.method_id !== want.method_id)
            report_mismatch($sformatf("method_id %0h, expected %0h",
                                      got.method_id, want.method_id));
        if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %0h, expected %0h",
                                      got.payload_byte, want.payload_byte));
        if (got.message_end !== want.message_end)
            report_mismatch($sformatf("message_end %0h, expected %0h",
                                      got.message_end, want.message_end));
    endtask

    // Both transactions of an edge are taken from the values held just before it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_payload    = 1'b0;
            hdr_pos       = '0;
            hdr_image     = '0;
            payload_taken = '0;
            pending_records.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                take_byte(i_data_byte);
            if (i_out_valid && !i_out_stall)
                check_record(seen_record);
        end
        o_pending <= pending_records.size();
    end

endmodule

>>> test/tb_rpc_frame_deframer_core.sv
`timescale 1ns / 1ps

// Top of the deframer testbench. It builds framed messages, feeds them into
// the block one byte per transaction and gives the verdict; all prediction
// and comparison happens in the stream checker that sits beside the block.
module tb_rpc_frame_deframer_core;
    import rfd_pkg::*;

    // Total bytes to send, directed ones included, before the closing long message.
    localparam int ITEM_TARGET   = 1000;
    // Cycles without any transaction on either channel before we give up.
    localparam int STALL_LIMIT   = 2000;
    // Margin waited after the drain before the verdict is given.
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall     = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [31:0] o_payload_length;
    logic [31:0] o_sequence_number;
    logic [15:0] o_err_code;
    logic [15:0] o_compress_kind;
    logic [15:0] o_stream_id;
    logic [15:0] o_method_id;
    logic [7:0]  o_payload_byte;
    logic        o_message_end;

    int          mismatches;
    int          records_pending;
    int          bytes_sent = 0;
    int          burst_left = 0;

    rpc_frame_deframer_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_payload_length  (o_payload_length),
        .o_sequence_number (o_sequence_number),
        .o_err_code        (o_err_code),
        .o_compress_kind   (o_compress_kind),
        .o_stream_id       (o_stream_id),
        .o_method_id       (o_method_id),
        .o_payload_byte    (o_payload_byte),
        .o_message_end     (o_message_end)
    );

    rfd_stream_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_data_byte       (i_data_byte),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_kind            (o_kind),
        .i_payload_length  (o_payload_length),
        .i_sequence_number (o_sequence_number),
        .i_err_code        (o_err_code),
        .i_compress_kind   (o_compress_kind),
        .i_stream_id       (o_stream_id),
        .i_method_id       (o_method_id),
        .i_payload_byte    (o_payload_byte),
        .i_message_end     (o_message_end),
        .o_mismatches      (mismatches),
        .o_pending         (records_pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Presents one byte and holds it, unchanged, until the block takes it.
    // The sender works in bursts: once a burst is used up, valid may drop
    // for a random gap. Within a burst valid simply stays high, so it is
    // never lowered and raised again at the same edge.
    task automatic send_byte(input t_byte b);
        int gap;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // Now and then a long burst gives a stretch with no idling at all.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Holds the sender back until every predicted record has been received.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (records_pending != 0);
    endtask

    // Sixteen-bit header fields favour the all-zero and all-one values.
    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Sends a header laid out little endian, followed by payload_count
    // payload bytes. A negative fill makes the payload random.
    task automatic send_message(input logic [31:0] length, input logic [31:0] seq,
                                input logic [15:0] code, input logic [15:0] compress,
                                input logic [15:0] stream, input logic [15:0] method,
                                input int payload_count, input int fill);
        logic [127:0] header;
        header = {method, stream, compress, code, seq, length};
        for (int i = 0; i < int'(HDR_BYTES); i++)
            send_byte(header[i*8 +: 8]);
        for (int i = 0; i < payload_count; i++)
            send_byte(fill < 0 ? t_byte'($urandom_range(0, 255)) : t_byte'(fill));
    endtask

    // Payload lengths: mostly short messages, a fair share of empty ones and
    // now and then a longer one.
    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 32'd0;
        else if (r < 75)
            return 32'($urandom_range(1, 8));
        else if (r < 95)
            return 32'($urandom_range(9, 40));
        return 32'($urandom_range(41, 200));
    endfunction

    // The receiver changes its behaviour every so often: no stalls, light or
    // heavy random stalling, or a fixed repeating stall pattern from an eight-bit word.
    initial begin : receiver
        int          mode;
        int          span;
        logic [7:0]  pattern;
        forever begin
            mode    = $urandom_range(0, 3);
            span    = $urandom_range(32, 200);
            pattern = 8'($urandom_range(0, 255));
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= pattern[k % 8];
                endcase
            end
        end
    end

    // Ends the run if neither channel completes a transaction for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[rpc_frame_deframer_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] length;
        burst_left = $urandom_range(1, 30);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: an empty message whose other header fields are all ones,
        // so the header record alone closes the message; then a one-byte
        // message whose other header fields are all zero.
        send_message(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
        send_message(32'd1, 32'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 8'hFF);
        wait_for_drain();

        // Random well-formed messages with random content.
        while (bytes_sent < ITEM_TARGET) begin
            length = pick_length();
            send_message(length, 32'($urandom), pick_field(), pick_field(),
                         pick_field(), pick_field(), int'(length), -1);
            if ($urandom_range(0, 19) == 0)
                wait_for_drain();
        end

        // Closing message with the largest length: it cannot complete within
        // the run, but the header record and the first payload bytes show
        // that the count does not end the message early.
        send_message(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     24, -1);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && records_pending == 0) begin
            $display("[rpc_frame_deframer_core] OK");
        end else begin
            $display("[rpc_frame_deframer_core] ERROR");
        end
        $finish;
    end

endmodule
